// ===== hdl/triangle_box_overlap_top_defines.svh =====
// assertion helpers shared by the checker
`ifndef TRIANGLE_BOX_OVERLAP_TOP_DEFINES_SVH
`define TRIANGLE_BOX_OVERLAP_TOP_DEFINES_SVH

// property checked outside reset
`define TBO_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// property checked on every edge, reset included
`define TBO_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== hdl/tbo_pkg.sv =====
`default_nettype none
package tbo_pkg;
  localparam int CW = 20;           // coordinate bits
  localparam int FieldW = 3 * CW;   // packed vertex / corner
  localparam int EW = CW + 1;       // coordinate differences
  localparam int PW = 2 * EW;       // product of two differences
  localparam int NW = PW + 1;       // normal component
  localparam int QW = NW + EW;      // normal times corner offset
  localparam int SW = QW + 2;       // sum of three such
  localparam int VW = PW + 4;       // edge function value

  localparam logic [2:0] RejNone   = 3'd0;
  localparam logic [2:0] RejBounds = 3'd1;
  localparam logic [2:0] RejPlane  = 3'd2;
  localparam logic [2:0] RejXy     = 3'd3;
  localparam logic [2:0] RejYz     = 3'd4;
  localparam logic [2:0] RejZx     = 3'd5;

  // projection j uses axes (f, s) and takes its sign from normal axis n
  localparam int ProjF [3] = '{0, 1, 2};
  localparam int ProjS [3] = '{1, 2, 0};
  localparam int ProjN [3] = '{2, 0, 1};

  typedef logic signed [CW-1:0] coord_t;
  typedef logic signed [EW-1:0] diff_t;
  typedef logic signed [PW-1:0] prod_t;
  typedef logic signed [NW-1:0] norm_t;
  typedef logic signed [QW-1:0] qprod_t;
  typedef logic signed [SW-1:0] psum_t;
  typedef logic signed [VW-1:0] eval_t;

  typedef struct packed {
    logic [FieldW-1:0] vertex_a;
    logic [FieldW-1:0] vertex_b;
    logic [FieldW-1:0] vertex_c;
    logic [FieldW-1:0] box_min;
    logic [FieldW-1:0] box_max;
  } req_t;

  typedef struct packed {
    logic       overlaps;
    logic [2:0] reject_stage;
  } res_t;

  // after unpack: edges, offsets from the box lower corner, extents
  typedef struct packed {
    logic                  bfail;
    diff_t [2:0][2:0]      ed;    // [edge][axis]
    diff_t [2:0][2:0]      lp;    // lo - vertex, [vertex][axis]
    diff_t [2:0]           hp0;   // hi - vertex a
    diff_t [2:0]           diag;
  } s1_t;

  // edge function partial products, [projection][edge]
  typedef struct packed {
    prod_t [2:0][2:0] pa;
    prod_t [2:0][2:0] pb;
    prod_t [2:0][2:0] pc;
    prod_t [2:0][2:0] pd;
  } eprod_t;

  typedef struct packed {
    logic        bfail;
    prod_t [5:0] np;
    eprod_t      ep;
    diff_t [2:0] lp0;
    diff_t [2:0] hp0;
  } s2_t;

  typedef struct packed {
    logic        bfail;
    norm_t [2:0] n;
    eprod_t      ep;
    diff_t [2:0] lp0;
    diff_t [2:0] hp0;
  } s3_t;
endpackage
`default_nettype wire

// ===== hdl/tbo_prep.sv =====
`default_nettype none
module tbo_prep (
  input  logic         clk,
  input  logic         rst,
  input  logic         en,
  input  logic         in_valid,
  input  tbo_pkg::req_t req,
  output logic         s1_valid,
  output tbo_pkg::s1_t s1
);
  import tbo_pkg::*;

  logic [2:0][FieldW-1:0] vert;
  coord_t [2:0][2:0] v;
  coord_t [2:0] lo, hi;
  s1_t s1_next;

  assign vert = {req.vertex_c, req.vertex_b, req.vertex_a};

  always_comb begin
    coord_t tmin, tmax;
    s1_next = '0;
    for (int a = 0; a < 3; a++) begin
      for (int k = 0; k < 3; k++) v[k][a] = coord_t'(vert[k][a*CW +: CW]);
      lo[a] = coord_t'(req.box_min[a*CW +: CW]);
      hi[a] = coord_t'(req.box_max[a*CW +: CW]);
    end
    for (int a = 0; a < 3; a++) begin
      tmin = v[0][a];
      tmax = v[0][a];
      for (int k = 1; k < 3; k++) begin
        if (v[k][a] < tmin) tmin = v[k][a];
        if (v[k][a] > tmax) tmax = v[k][a];
      end
      if (tmin > hi[a] || tmax < lo[a]) s1_next.bfail = 1'b1;
      s1_next.hp0[a]  = EW'(hi[a]) - EW'(v[0][a]);
      s1_next.diag[a] = EW'(hi[a]) - EW'(lo[a]);
      for (int i = 0; i < 3; i++) begin
        s1_next.ed[i][a] = EW'(v[(i + 1) % 3][a]) - EW'(v[i][a]);
        s1_next.lp[i][a] = EW'(lo[a]) - EW'(v[i][a]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (en) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1 <= s1_next;
    end
  end
endmodule
`default_nettype wire

// ===== hdl/tbo_mul.sv =====
`default_nettype none
module tbo_mul (
  input  logic         clk,
  input  logic         rst,
  input  logic         en,
  input  logic         s1_valid,
  input  tbo_pkg::s1_t s1,
  output logic         s3_valid,
  output tbo_pkg::s3_t s3
);
  import tbo_pkg::*;

  logic s2_valid;
  s2_t  s2, s2_next;
  s3_t  s3_next;

  function automatic prod_t mul(input diff_t a, input diff_t b);
    mul = PW'(a) * PW'(b);
  endfunction

  always_comb begin
    int f, s;
    s2_next = '0;
    s2_next.bfail = s1.bfail;
    s2_next.lp0   = s1.lp[0];
    s2_next.hp0   = s1.hp0;
    // cross product terms of edge a->b and edge b->c
    s2_next.np[0] = mul(s1.ed[0][1], s1.ed[1][2]);
    s2_next.np[1] = mul(s1.ed[0][2], s1.ed[1][1]);
    s2_next.np[2] = mul(s1.ed[0][2], s1.ed[1][0]);
    s2_next.np[3] = mul(s1.ed[0][0], s1.ed[1][2]);
    s2_next.np[4] = mul(s1.ed[0][0], s1.ed[1][1]);
    s2_next.np[5] = mul(s1.ed[0][1], s1.ed[1][0]);
    for (int j = 0; j < 3; j++) begin
      f = ProjF[j];
      s = ProjS[j];
      for (int i = 0; i < 3; i++) begin
        s2_next.ep.pa[j][i] = mul(s1.ed[i][s], s1.lp[i][f]);
        s2_next.ep.pb[j][i] = mul(s1.ed[i][f], s1.lp[i][s]);
        s2_next.ep.pc[j][i] = mul(s1.ed[i][s], s1.diag[f]);
        s2_next.ep.pd[j][i] = mul(s1.ed[i][f], s1.diag[s]);
      end
    end
  end

  always_comb begin
    s3_next.bfail = s2.bfail;
    s3_next.ep    = s2.ep;
    s3_next.lp0   = s2.lp0;
    s3_next.hp0   = s2.hp0;
    s3_next.n[0]  = NW'(s2.np[0]) - NW'(s2.np[1]);
    s3_next.n[1]  = NW'(s2.np[2]) - NW'(s2.np[3]);
    s3_next.n[2]  = NW'(s2.np[4]) - NW'(s2.np[5]);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
    end else if (en) begin
      s2_valid <= s1_valid;
      s3_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s2 <= s2_next;
      s3 <= s3_next;
    end
  end
endmodule
`default_nettype wire

// ===== hdl/tbo_decide.sv =====
`default_nettype none
module tbo_decide (
  input  logic          clk,
  input  logic          rst,
  input  logic          en,
  input  logic          s3_valid,
  input  tbo_pkg::s3_t  s3,
  output logic          res_valid,
  output tbo_pkg::res_t res
);
  import tbo_pkg::*;

  logic          s4_valid;
  logic          s4_bfail;
  qprod_t [2:0]  qmax, qmin, qmax_next, qmin_next;
  logic   [2:0]  pfail, pfail_next;
  res_t          res_next;

  function automatic prod_t pos(input prod_t x);
    pos = (x > 0) ? x : '0;
  endfunction

  always_comb begin
    diff_t cmax, cmin;
    logic  neg;
    eval_t val;
    for (int a = 0; a < 3; a++) begin
      // critical corners relative to vertex a
      cmax = (s3.n[a] > 0) ? s3.hp0[a] : s3.lp0[a];
      cmin = (s3.n[a] > 0) ? s3.lp0[a] : s3.hp0[a];
      qmax_next[a] = QW'(s3.n[a]) * QW'(cmax);
      qmin_next[a] = QW'(s3.n[a]) * QW'(cmin);
    end
    for (int j = 0; j < 3; j++) begin
      neg = s3.n[ProjN[j]] < 0;
      pfail_next[j] = 1'b0;
      for (int i = 0; i < 3; i++) begin
        if (neg)
          val = VW'(s3.ep.pa[j][i]) - VW'(s3.ep.pb[j][i])
              + VW'(pos(s3.ep.pc[j][i])) + VW'(pos(-s3.ep.pd[j][i]));
        else
          val = VW'(s3.ep.pb[j][i]) - VW'(s3.ep.pa[j][i])
              + VW'(pos(-s3.ep.pc[j][i])) + VW'(pos(s3.ep.pd[j][i]));
        if (val < 0) pfail_next[j] = 1'b1;
      end
    end
  end

  always_comb begin
    psum_t smax, smin;
    logic  plane_rej;
    smax = SW'(qmax[0]) + SW'(qmax[1]) + SW'(qmax[2]);
    smin = SW'(qmin[0]) + SW'(qmin[1]) + SW'(qmin[2]);
    plane_rej = (smax > 0 && smin > 0) || (smax < 0 && smin < 0);
    if (s4_bfail)      res_next.reject_stage = RejBounds;
    else if (plane_rej) res_next.reject_stage = RejPlane;
    else if (pfail[0])  res_next.reject_stage = RejXy;
    else if (pfail[1])  res_next.reject_stage = RejYz;
    else if (pfail[2])  res_next.reject_stage = RejZx;
    else                res_next.reject_stage = RejNone;
    res_next.overlaps = (res_next.reject_stage == RejNone);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s4_valid  <= 1'b0;
      res_valid <= 1'b0;
    end else if (en) begin
      s4_valid  <= s3_valid;
      res_valid <= s4_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s4_bfail <= s3.bfail;
      qmax     <= qmax_next;
      qmin     <= qmin_next;
      pfail    <= pfail_next;
      res      <= res_next;
    end
  end
endmodule
`default_nettype wire

// ===== hdl/triangle_box_overlap_top.sv =====
// channel | handshake                  | payload
// request | req_valid / req_ready      | req_data  (tbo_pkg::req_t)
// result  | res_valid / res_ready      | res_data  (tbo_pkg::res_t)
//
// five register stages: unpack and bounds, products, normal,
// plane products and edge functions, result register
// one request per cycle while no result waits unaccepted
// all stages advance together; they hold while a result waits unaccepted
// rst clears the valid bits only
`default_nettype none
module triangle_box_overlap_top (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_ready,
  input  tbo_pkg::req_t req_data,
  output logic          res_valid,
  input  logic          res_ready,
  output tbo_pkg::res_t res_data
);
  import tbo_pkg::*;

  logic en;
  logic s1_valid, s3_valid;
  s1_t  s1;
  s3_t  s3;

  assign en        = !res_valid || res_ready;
  assign req_ready = en;

  tbo_prep u_prep (
    .clk, .rst, .en,
    .in_valid (req_valid),
    .req      (req_data),
    .s1_valid,
    .s1
  );

  tbo_mul u_mul (
    .clk, .rst, .en,
    .s1_valid,
    .s1,
    .s3_valid,
    .s3
  );

  tbo_decide u_decide (
    .clk, .rst, .en,
    .s3_valid,
    .s3,
    .res_valid,
    .res (res_data)
  );
endmodule
`default_nettype wire

// ===== hdl/tbo_checker.sv =====
`default_nettype none
`include "triangle_box_overlap_top_defines.svh"
module tbo_checker (
  input logic          clk,
  input logic          rst,
  input logic          req_valid,
  input logic          req_ready,
  input tbo_pkg::req_t req_data,
  input logic          res_valid,
  input logic          res_ready,
  input tbo_pkg::res_t res_data
);
  import tbo_pkg::*;

  `TBO_ASSERT_RST(a_reset_empty, rst |=> !res_valid, "result valid after reset")
  `TBO_ASSERT(a_res_hold, res_valid && !res_ready |=> res_valid && $stable(res_data), "result dropped")
  `TBO_ASSERT(a_flag_match, res_valid |-> res_data.overlaps == (res_data.reject_stage == RejNone), "flag mismatch")
  `TBO_ASSERT(a_code_range, res_valid |-> res_data.reject_stage <= RejZx, "bad reject code")
  `TBO_ASSERT(a_ready_free, !res_valid |-> req_ready, "request stalled while output empty")
endmodule

bind triangle_box_overlap_top tbo_checker u_tbo_checker (
  .clk, .rst, .req_valid, .req_ready, .req_data, .res_valid, .res_ready, .res_data
);
`default_nettype wire
